// ===== design/sm_pkg.sv =====
// Shared types, constants and opcodes of the stack machine core.
package sm_pkg;

  localparam int unsigned MEM_WORDS  = 4096;
  localparam int unsigned WORD_BYTES = 8;
  localparam int unsigned MEM_BYTES  = MEM_WORDS * WORD_BYTES;
  localparam int unsigned ADDR_W     = $clog2(MEM_BYTES);
  localparam int unsigned IDX_W      = $clog2(MEM_WORDS);
  localparam int unsigned LANE_W     = $clog2(WORD_BYTES);
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned DIV_CW     = $clog2(DATA_W) + 1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_START = 2'd2,
    ACT_READ  = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXIT    = 3'd1,
    ST_DIVZ    = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_SYSCALL = 3'd4,
    ST_BADACC  = 3'd5,
    ST_HALTED  = 3'd6
  } status_e;

  localparam logic [5:0] OP_LEA  = 6'd0;
  localparam logic [5:0] OP_IMM  = 6'd1;
  localparam logic [5:0] OP_JMP  = 6'd2;
  localparam logic [5:0] OP_JSR  = 6'd3;
  localparam logic [5:0] OP_BZ   = 6'd4;
  localparam logic [5:0] OP_BNZ  = 6'd5;
  localparam logic [5:0] OP_ENT  = 6'd6;
  localparam logic [5:0] OP_ADJ  = 6'd7;
  localparam logic [5:0] OP_LEV  = 6'd8;
  localparam logic [5:0] OP_LI   = 6'd9;
  localparam logic [5:0] OP_LC   = 6'd10;
  localparam logic [5:0] OP_SI   = 6'd11;
  localparam logic [5:0] OP_SC   = 6'd12;
  localparam logic [5:0] OP_PSH  = 6'd13;
  localparam logic [5:0] OP_OR   = 6'd14;
  localparam logic [5:0] OP_XOR  = 6'd15;
  localparam logic [5:0] OP_AND  = 6'd16;
  localparam logic [5:0] OP_EQ   = 6'd17;
  localparam logic [5:0] OP_NE   = 6'd18;
  localparam logic [5:0] OP_LT   = 6'd19;
  localparam logic [5:0] OP_GT   = 6'd20;
  localparam logic [5:0] OP_LE   = 6'd21;
  localparam logic [5:0] OP_GE   = 6'd22;
  localparam logic [5:0] OP_SHL  = 6'd23;
  localparam logic [5:0] OP_SHR  = 6'd24;
  localparam logic [5:0] OP_ADD  = 6'd25;
  localparam logic [5:0] OP_SUB  = 6'd26;
  localparam logic [5:0] OP_MUL  = 6'd27;
  localparam logic [5:0] OP_DIV  = 6'd28;
  localparam logic [5:0] OP_MOD  = 6'd29;
  localparam logic [5:0] OP_SYS0 = 6'd30;
  localparam logic [5:0] OP_SYS7 = 6'd37;
  localparam logic [5:0] OP_EXIT = 6'd38;

  typedef struct packed {
    act_e               action;
    logic [14:0]        address;
    logic signed [63:0] value;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [14:0]        program_counter;
    logic signed [63:0] accumulator;
    logic signed [63:0] read_data;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== design/sm_ram.sv =====
// Generic single-port RAM with registered read data.
module sm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/sm_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sm_div import sm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output div_stat_t         stat_o,
  output logic [DATA_W-1:0] quot_o,
  output logic [DATA_W-1:0] rem_o
);

  logic [DATA_W-1:0] dvd_q, dvs_q, rem_q, rem_sh;
  logic [DIV_CW-1:0] cnt_q;
  logic              qneg_q, rneg_q, busy_q, done_q, fits;

  assign rem_sh = {rem_q[DATA_W-2:0], dvd_q[DATA_W-1]};
  assign fits   = (rem_sh >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      cnt_q  <= '0;
      qneg_q <= 1'b0;
      rneg_q <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        // work on magnitudes, fix signs at the end
        dvd_q  <= dividend_i[DATA_W-1] ? -dividend_i : dividend_i;
        dvs_q  <= divisor_i[DATA_W-1] ? -divisor_i : divisor_i;
        rem_q  <= '0;
        cnt_q  <= DIV_CW'(DATA_W);
        qneg_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
        rneg_q <= dividend_i[DATA_W-1];
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= fits ? (rem_sh - dvs_q) : rem_sh;
        dvd_q <= {dvd_q[DATA_W-2:0], fits};
        cnt_q <= cnt_q - DIV_CW'(1);
        if (cnt_q == DIV_CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = qneg_q ? -dvd_q : dvd_q;
  assign rem_o       = rneg_q ? -rem_q : rem_q;

endmodule

// ===== design/stack_machine_core.sv =====
// Stack machine core: sequencer around one word memory, APB config registers.
// Host write and start pass through S_OUT into the output register; a host read passes S_HRD first.
// An instruction's opcode fetch, immediate fetch, stack and data access share the one memory
// port; multiply steps through S_MUL, and divide and modulo wait in S_DIV on the divider.
// One item is in flight at a time; a new beat is taken while a result waits at the output.
// Reset: pc 0, sp and bp 32768, acc 0, core halted until start; memory undefined until written.
module stack_machine_core import sm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_HRD, S_OP, S_IMM, S_X, S_LEV1, S_LEV2, S_LD,
    S_POP, S_ALU, S_SCW, S_MUL, S_DIV, S_OUT
  } state_e;

  function automatic logic word_ok(input logic [63:0] a);
    return (a[LANE_W-1:0] == '0) && (a < 64'(MEM_BYTES));
  endfunction

  function automatic logic [IDX_W-1:0] widx(input logic [63:0] a);
    return a[ADDR_W-1:LANE_W];
  endfunction

  function automatic logic [63:0] sext8(input logic [7:0] b);
    return {{56{b[7]}}, b};
  endfunction

  state_e      state_q, state_d;
  logic [14:0] pc_q, pc_d, start_q;
  logic [15:0] sp_q, sp_d, bp_q, bp_d, stack_q, nxt_q, nxt_d;
  logic [63:0] acc_q, acc_d, imm_q, imm_d, x_q, x_d;
  logic [63:0] prod_q, prod_d, mres_q, mres_d, res_rdata_q, res_rdata_d;
  logic [5:0]  op_q, op_d;
  logic [1:0]  mcnt_q, mcnt_d;
  logic        halted_q, halted_d, out_valid_q, out_valid_d;
  status_e     res_status_q, res_status_d;
  out_t        out_q, out_d;

  logic             mem_we;
  logic [IDX_W-1:0] mem_addr;
  logic [63:0]      mem_wdata, mem_rdata;
  logic             div_start;
  div_stat_t        div_stat;
  logic [63:0]      div_quot, div_rem;
  logic [31:0]      mul_a, mul_b;
  logic [63:0]      mul_p;

  logic [15:0] sp_m8, sp_p8, bp_p8, bp_p16, pc_p8, op_nxt;
  logic [63:0] imm8, ent_t, adj_t, br_t, lc_word, sc_mask, sc_byte;
  logic [5:0]  op_w;
  logic        push_ok, sp_ok, nxt_ok, cfg_we;

  sm_ram #(.WIDTH(64), .DEPTH(MEM_WORDS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  sm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mem_rdata),
    .divisor_i  (acc_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = paddr[2] ? {16'd0, stack_q} : {17'd0, start_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      stack_q <= 16'd32768;
    end else if (cfg_we) begin
      if (paddr[2]) begin
        stack_q <= pwdata[15:0];
      end else begin
        start_q <= pwdata[14:0];
      end
    end
  end

  assign sp_m8   = sp_q - 16'(WORD_BYTES);
  assign sp_p8   = sp_q + 16'(WORD_BYTES);
  assign bp_p8   = bp_q + 16'(WORD_BYTES);
  assign bp_p16  = bp_q + 16'(2 * WORD_BYTES);
  assign pc_p8   = {1'b0, pc_q} + 16'(WORD_BYTES);
  assign op_w    = mem_rdata[5:0];
  assign op_nxt  = (op_w <= OP_ADJ) ? (pc_p8 + 16'(WORD_BYTES)) : pc_p8;
  assign push_ok = (sp_q >= 16'(WORD_BYTES)) && word_ok(64'(sp_m8));
  assign sp_ok   = word_ok(64'(sp_q));
  assign nxt_ok  = word_ok(64'(nxt_q));
  assign imm8    = imm_q << LANE_W;
  assign ent_t   = 64'(sp_m8) - imm8;
  assign adj_t   = 64'(sp_q) + imm8;
  assign br_t    = ((acc_q == '0) == (op_q == OP_BZ)) ? imm_q : 64'(nxt_q);
  assign lc_word = mem_rdata >> {acc_q[LANE_W-1:0], 3'b000};
  assign sc_mask = 64'hFF << {x_q[LANE_W-1:0], 3'b000};
  assign sc_byte = {56'd0, acc_q[7:0]} << {x_q[LANE_W-1:0], 3'b000};
  assign mul_p   = mul_a * mul_b;

  always_comb begin
    state_d      = state_q;
    pc_d         = pc_q;
    sp_d         = sp_q;
    bp_d         = bp_q;
    acc_d        = acc_q;
    halted_d     = halted_q;
    op_d         = op_q;
    nxt_d        = nxt_q;
    imm_d        = imm_q;
    x_d          = x_q;
    prod_d       = prod_q;
    mres_d       = mres_q;
    mcnt_d       = mcnt_q;
    res_status_d = res_status_q;
    res_rdata_d  = res_rdata_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    mem_we       = 1'b0;
    mem_addr     = widx(64'(pc_q));
    mem_wdata    = acc_q;
    div_start    = 1'b0;
    mul_a        = x_q[31:0];
    mul_b        = acc_q[31:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_rdata_d  = '0;
          state_d      = S_OUT;
          unique case (in_data_i.action)
            ACT_WRITE: begin
              if (word_ok(64'(in_data_i.address))) begin
                mem_we    = 1'b1;
                mem_addr  = widx(64'(in_data_i.address));
                mem_wdata = in_data_i.value;
              end else begin
                res_status_d = ST_BADACC;
              end
            end
            ACT_READ: begin
              if (word_ok(64'(in_data_i.address))) begin
                mem_addr = widx(64'(in_data_i.address));
                state_d  = S_HRD;
              end else begin
                res_status_d = ST_BADACC;
              end
            end
            ACT_START: begin
              pc_d     = start_q;
              sp_d     = stack_q;
              bp_d     = stack_q;
              acc_d    = '0;
              halted_d = 1'b0;
            end
            ACT_EXEC: begin
              if (halted_q) begin
                res_status_d = ST_HALTED;
              end else if (!word_ok(64'(pc_q))) begin
                res_status_d = ST_BADACC;
                halted_d     = 1'b1;
              end else begin
                state_d = S_OP;
              end
            end
            default: ;
          endcase
        end
      end

      S_HRD: begin
        res_rdata_d = mem_rdata;
        state_d     = S_OUT;
      end

      S_OP: begin
        op_d    = op_w;
        nxt_d   = op_nxt;
        state_d = S_OUT;
        if (mem_rdata > 64'(OP_EXIT)) begin
          res_status_d = ST_UNKNOWN;
          halted_d     = 1'b1;
        end else if (op_w >= OP_SYS0 && op_w <= OP_SYS7) begin
          res_status_d = ST_SYSCALL;
          halted_d     = 1'b1;
        end else if (op_w <= OP_ADJ) begin
          if (!word_ok(64'(pc_p8))) begin
            res_status_d = ST_BADACC;
            halted_d     = 1'b1;
          end else begin
            mem_addr = widx(64'(pc_p8));
            state_d  = S_IMM;
          end
        end else if (!word_ok(64'(op_nxt)) && op_w != OP_LEV && op_w != OP_EXIT) begin
          res_status_d = ST_BADACC;
          halted_d     = 1'b1;
        end else begin
          case (op_w)
            OP_LEV: begin
              if (!word_ok(64'(bp_q)) || !word_ok(64'(bp_p8))) begin
                res_status_d = ST_BADACC;
                halted_d     = 1'b1;
              end else begin
                mem_addr = widx(64'(bp_q));
                state_d  = S_LEV1;
              end
            end
            OP_LI: begin
              if (!word_ok(acc_q)) begin
                res_status_d = ST_BADACC;
                halted_d     = 1'b1;
              end else begin
                mem_addr = widx(acc_q);
                state_d  = S_LD;
              end
            end
            OP_LC: begin
              if (acc_q >= 64'(MEM_BYTES)) begin
                res_status_d = ST_BADACC;
                halted_d     = 1'b1;
              end else begin
                mem_addr = widx(acc_q);
                state_d  = S_LD;
              end
            end
            OP_PSH: begin
              if (!push_ok) begin
                res_status_d = ST_BADACC;
                halted_d     = 1'b1;
              end else begin
                mem_we    = 1'b1;
                mem_addr  = widx(64'(sp_m8));
                mem_wdata = acc_q;
                sp_d      = sp_m8;
                pc_d      = op_nxt[14:0];
              end
            end
            default: begin
              // pop-type ops all read the top of stack first
              if (!sp_ok) begin
                res_status_d = ST_BADACC;
                halted_d     = 1'b1;
              end else begin
                mem_addr = widx(64'(sp_q));
                state_d  = S_POP;
              end
            end
          endcase
        end
      end

      S_IMM: begin
        imm_d   = mem_rdata;
        state_d = S_X;
      end

      S_X: begin
        state_d = S_OUT;
        case (op_q) inside
          OP_LEA, OP_IMM: begin
            if (!nxt_ok) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              acc_d = (op_q == OP_LEA) ? (64'(bp_q) + imm8) : imm_q;
              pc_d  = nxt_q[14:0];
            end
          end
          OP_JMP: begin
            if (!word_ok(imm_q)) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              pc_d = imm_q[14:0];
            end
          end
          OP_JSR: begin
            if (!word_ok(imm_q) || !push_ok) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = widx(64'(sp_m8));
              mem_wdata = 64'(nxt_q);
              sp_d      = sp_m8;
              pc_d      = imm_q[14:0];
            end
          end
          OP_BZ, OP_BNZ: begin
            if (!word_ok(br_t)) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              pc_d = br_t[14:0];
            end
          end
          OP_ENT: begin
            if (!nxt_ok || !push_ok || ent_t > 64'(MEM_BYTES)) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = widx(64'(sp_m8));
              mem_wdata = 64'(bp_q);
              bp_d      = sp_m8;
              sp_d      = ent_t[15:0];
              pc_d      = nxt_q[14:0];
            end
          end
          OP_ADJ: begin
            if (!nxt_ok || adj_t > 64'(MEM_BYTES)) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              sp_d = adj_t[15:0];
              pc_d = nxt_q[14:0];
            end
          end
          default: begin
            res_status_d = ST_UNKNOWN;
            halted_d     = 1'b1;
          end
        endcase
      end

      S_LEV1: begin
        x_d      = mem_rdata;
        mem_addr = widx(64'(bp_p8));
        state_d  = S_LEV2;
      end

      S_LEV2: begin
        state_d = S_OUT;
        if (x_q > 64'(MEM_BYTES) || !word_ok(mem_rdata)) begin
          res_status_d = ST_BADACC;
          halted_d     = 1'b1;
        end else begin
          sp_d = bp_p16;
          bp_d = x_q[15:0];
          pc_d = mem_rdata[14:0];
        end
      end

      S_LD: begin
        acc_d   = (op_q == OP_LI) ? mem_rdata : sext8(lc_word[7:0]);
        pc_d    = nxt_q[14:0];
        state_d = S_OUT;
      end

      S_POP: begin
        x_d     = mem_rdata;
        state_d = S_OUT;
        case (op_q) inside
          OP_EXIT: begin
            res_status_d = ST_EXIT;
            res_rdata_d  = mem_rdata;
            halted_d     = 1'b1;
          end
          OP_SI: begin
            if (!word_ok(mem_rdata)) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              mem_we    = 1'b1;
              mem_addr  = widx(mem_rdata);
              mem_wdata = acc_q;
              sp_d      = sp_p8;
              pc_d      = nxt_q[14:0];
            end
          end
          OP_SC: begin
            if (mem_rdata >= 64'(MEM_BYTES)) begin
              res_status_d = ST_BADACC;
              halted_d     = 1'b1;
            end else begin
              mem_addr = widx(mem_rdata);
              state_d  = S_SCW;
            end
          end
          OP_MUL: begin
            mcnt_d  = '0;
            state_d = S_MUL;
          end
          OP_DIV, OP_MOD: begin
            if (acc_q == '0) begin
              res_status_d = ST_DIVZ;
              halted_d     = 1'b1;
            end else if (acc_q == '1) begin
              acc_d = (op_q == OP_DIV) ? -mem_rdata : '0;
              sp_d  = sp_p8;
              pc_d  = nxt_q[14:0];
            end else begin
              div_start = 1'b1;
              state_d   = S_DIV;
            end
          end
          default: state_d = S_ALU;
        endcase
      end

      S_ALU: begin
        case (op_q)
          OP_OR:   acc_d = x_q | acc_q;
          OP_XOR:  acc_d = x_q ^ acc_q;
          OP_AND:  acc_d = x_q & acc_q;
          OP_EQ:   acc_d = 64'(x_q == acc_q);
          OP_NE:   acc_d = 64'(x_q != acc_q);
          OP_LT:   acc_d = 64'($signed(x_q) < $signed(acc_q));
          OP_GT:   acc_d = 64'($signed(x_q) > $signed(acc_q));
          OP_LE:   acc_d = 64'($signed(x_q) <= $signed(acc_q));
          OP_GE:   acc_d = 64'($signed(x_q) >= $signed(acc_q));
          OP_SHL:  acc_d = x_q << acc_q[5:0];
          OP_SHR:  acc_d = $unsigned($signed(x_q) >>> acc_q[5:0]);
          OP_ADD:  acc_d = x_q + acc_q;
          default: acc_d = x_q - acc_q;
        endcase
        sp_d    = sp_p8;
        pc_d    = nxt_q[14:0];
        state_d = S_OUT;
      end

      S_SCW: begin
        mem_we    = 1'b1;
        mem_addr  = widx(x_q);
        mem_wdata = (mem_rdata & ~sc_mask) | sc_byte;
        acc_d     = sext8(acc_q[7:0]);
        sp_d      = sp_p8;
        pc_d      = nxt_q[14:0];
        state_d   = S_OUT;
      end

      S_MUL: begin
        // low word only: lo*lo + ((lo*hi + hi*lo) << 32), one 32x32 product a cycle
        mcnt_d = mcnt_q + 2'd1;
        prod_d = mul_p;
        case (mcnt_q)
          2'd0: begin
            mul_a = x_q[31:0];
            mul_b = acc_q[31:0];
          end
          2'd1: begin
            mul_a  = x_q[31:0];
            mul_b  = acc_q[63:32];
            mres_d = prod_q;
          end
          2'd2: begin
            mul_a  = x_q[63:32];
            mul_b  = acc_q[31:0];
            mres_d = {mres_q[63:32] + prod_q[31:0], mres_q[31:0]};
          end
          default: begin
            acc_d   = {mres_q[63:32] + prod_q[31:0], mres_q[31:0]};
            sp_d    = sp_p8;
            pc_d    = nxt_q[14:0];
            state_d = S_OUT;
          end
        endcase
      end

      S_DIV: begin
        if (div_stat.done) begin
          acc_d   = (op_q == OP_DIV) ? div_quot : div_rem;
          sp_d    = sp_p8;
          pc_d    = nxt_q[14:0];
          state_d = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status          = res_status_q;
          out_d.program_counter = pc_q;
          out_d.accumulator     = acc_q;
          out_d.read_data       = res_rdata_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pc_q         <= '0;
      sp_q         <= 16'd32768;
      bp_q         <= 16'd32768;
      acc_q        <= '0;
      halted_q     <= 1'b1;
      op_q         <= '0;
      nxt_q        <= '0;
      imm_q        <= '0;
      x_q          <= '0;
      prod_q       <= '0;
      mres_q       <= '0;
      mcnt_q       <= '0;
      res_status_q <= ST_OK;
      res_rdata_q  <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pc_q         <= pc_d;
      sp_q         <= sp_d;
      bp_q         <= bp_d;
      acc_q        <= acc_d;
      halted_q     <= halted_d;
      op_q         <= op_d;
      nxt_q        <= nxt_d;
      imm_q        <= imm_d;
      x_q          <= x_d;
      prod_q       <= prod_d;
      mres_q       <= mres_d;
      mcnt_q       <= mcnt_d;
      res_status_q <= res_status_d;
      res_rdata_q  <= res_rdata_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while core idle");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");

  a_exec_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && state_q != S_IDLE) |-> !halted_q)
    else $error("memory written by a halted core");

endmodule

// ===== dv/sm_checker.sv =====
// Scoreboard for stack_machine_core: tracks config, predicts each beat, compares results.
module sm_checker import sm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_t         in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_t        out_data_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  logic [63:0] mem_q [MEM_WORDS];
  logic [63:0] pc_q, sp_q, bp_q, acc_q;
  logic        halted_q;
  logic [14:0] start_addr_q;
  logic [15:0] stack_top_q;
  out_t        expected_results [$];

  function automatic bit word_ok(logic [63:0] ad);
    return ad[2:0] == 3'd0 && ad < 64'(MEM_BYTES);
  endfunction

  function automatic logic [63:0] mem_rd(logic [63:0] ad);
    return mem_q[ad[14:3]];
  endfunction

  function automatic logic [63:0] sext8(logic [63:0] v);
    return {{56{v[7]}}, v[7:0]};
  endfunction

  function automatic status_e run_instruction(output logic [63:0] exit_code);
    logic [63:0] pc, sp, bp, a, op, imm, nxt, x, y, t;
    logic [5:0]  lane;
    pc = pc_q; sp = sp_q; bp = bp_q; a = acc_q; imm = '0; exit_code = '0;
    if (!word_ok(pc)) return ST_BADACC;
    op = mem_rd(pc);
    if (op > 64'(OP_EXIT)) return ST_UNKNOWN;
    if (op >= 64'(OP_SYS0) && op <= 64'(OP_SYS7)) return ST_SYSCALL;
    if (op <= 64'(OP_ADJ)) begin
      if (!word_ok(pc + 8)) return ST_BADACC;
      imm = mem_rd(pc + 8);
      nxt = pc + 16;
    end else begin
      nxt = pc + 8;
    end
    // control-flow ops validate their own target, and exit needs no next pc
    if (!(op[5:0] inside {OP_JMP, OP_JSR, OP_BZ, OP_BNZ, OP_LEV, OP_EXIT}) && !word_ok(nxt))
      return ST_BADACC;
    case (op[5:0])
      OP_LEA: begin a = bp + imm * 8; pc = nxt; end
      OP_IMM: begin a = imm; pc = nxt; end
      OP_JMP: begin
        if (!word_ok(imm)) return ST_BADACC;
        pc = imm;
      end
      OP_JSR: begin
        if (!word_ok(imm) || sp < 8 || !word_ok(sp - 8)) return ST_BADACC;
        sp = sp - 8; mem_q[sp[14:3]] = nxt; pc = imm;
      end
      OP_BZ, OP_BNZ: begin
        t = ((a == 0) == (op[5:0] == OP_BZ)) ? imm : nxt;
        if (!word_ok(t)) return ST_BADACC;
        pc = t;
      end
      OP_ENT: begin
        if (sp < 8 || !word_ok(sp - 8)) return ST_BADACC;
        t = sp - 8 - imm * 8;
        if (t > 64'(MEM_BYTES)) return ST_BADACC;
        mem_q[sp[14:3] - 12'd1] = bp; bp = sp - 8; sp = t; pc = nxt;
      end
      OP_ADJ: begin
        t = sp + imm * 8;
        if (t > 64'(MEM_BYTES)) return ST_BADACC;
        sp = t; pc = nxt;
      end
      OP_LEV: begin
        if (!word_ok(bp) || !word_ok(bp + 8)) return ST_BADACC;
        x = mem_rd(bp); y = mem_rd(bp + 8);
        if (x > 64'(MEM_BYTES) || !word_ok(y)) return ST_BADACC;
        sp = bp + 16; bp = x; pc = y;
      end
      OP_LI: begin
        if (!word_ok(a)) return ST_BADACC;
        a = mem_rd(a); pc = nxt;
      end
      OP_LC: begin
        if (a >= 64'(MEM_BYTES)) return ST_BADACC;
        a = sext8(mem_rd(a) >> {a[2:0], 3'b000}); pc = nxt;
      end
      OP_SI, OP_SC: begin
        if (!word_ok(sp)) return ST_BADACC;
        t = mem_rd(sp);
        if (op[5:0] == OP_SI) begin
          if (!word_ok(t)) return ST_BADACC;
          mem_q[t[14:3]] = a;
        end else begin
          if (t >= 64'(MEM_BYTES)) return ST_BADACC;
          lane = {t[2:0], 3'b000};
          x = mem_rd(t) & ~(64'hFF << lane);
          mem_q[t[14:3]] = x | ({56'd0, a[7:0]} << lane);
          a = sext8(a);
        end
        sp = sp + 8; pc = nxt;
      end
      OP_PSH: begin
        if (sp < 8 || !word_ok(sp - 8)) return ST_BADACC;
        sp = sp - 8; mem_q[sp[14:3]] = a; pc = nxt;
      end
      OP_EXIT: begin
        if (!word_ok(sp)) return ST_BADACC;
        exit_code = mem_rd(sp);
        return ST_EXIT;
      end
      default: begin
        if (!word_ok(sp)) return ST_BADACC;
        x = mem_rd(sp);
        case (op[5:0])
          OP_OR:  a = x | a;
          OP_XOR: a = x ^ a;
          OP_AND: a = x & a;
          OP_EQ:  a = 64'(x == a);
          OP_NE:  a = 64'(x != a);
          OP_LT:  a = 64'($signed(x) < $signed(a));
          OP_GT:  a = 64'($signed(x) > $signed(a));
          OP_LE:  a = 64'($signed(x) <= $signed(a));
          OP_GE:  a = 64'($signed(x) >= $signed(a));
          OP_SHL: a = x << a[5:0];
          OP_SHR: a = $signed(x) >>> a[5:0];
          OP_ADD: a = x + a;
          OP_SUB: a = x - a;
          OP_MUL: a = x * a;
          default: begin
            if (a == 0) return ST_DIVZ;
            // divisor -1 handled apart: min / -1 overflows
            if (a == '1) a = (op[5:0] == OP_DIV) ? (64'd0 - x) : 64'd0;
            else if (op[5:0] == OP_DIV) a = $signed(x) / $signed(a);
            else a = $signed(x) % $signed(a);
          end
        endcase
        sp = sp + 8; pc = nxt;
      end
    endcase
    pc_q = pc; sp_q = sp; bp_q = bp; acc_q = a;
    return ST_OK;
  endfunction

  function automatic out_t apply_beat(in_t b);
    out_t        r;
    logic [63:0] ad, rdata;
    status_e     st;
    ad = 64'(b.address);
    rdata = '0;
    st = ST_OK;
    case (b.action)
      ACT_WRITE: if (word_ok(ad)) mem_q[ad[14:3]] = b.value; else st = ST_BADACC;
      ACT_READ:  if (word_ok(ad)) rdata = mem_rd(ad); else st = ST_BADACC;
      ACT_START: begin
        pc_q = 64'(start_addr_q); sp_q = 64'(stack_top_q); bp_q = 64'(stack_top_q);
        acc_q = '0; halted_q = 1'b0;
      end
      default: begin
        if (halted_q) st = ST_HALTED;
        else begin
          st = run_instruction(rdata);
          if (st != ST_OK) halted_q = 1'b1;
          if (st != ST_EXIT) rdata = '0;
        end
      end
    endcase
    r.status = st;
    r.program_counter = pc_q[14:0];
    r.accumulator = acc_q;
    r.read_data = rdata;
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t got, want;
    if (!rst_ni) begin
      pc_q = '0; sp_q = 64'd32768; bp_q = 64'd32768; acc_q = '0; halted_q = 1'b1;
      start_addr_q = '0; stack_top_q = 16'd32768;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == 3'd0) start_addr_q = pwdata[14:0];
        else if (paddr == 3'd4) stack_top_q = pwdata[15:0];
      end
      if (in_valid_i && in_ready_i) expected_results.push_back(apply_beat(in_data_i));
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count = fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count = fail_count + 1;
          end
          if (got.program_counter !== want.program_counter) begin
            $error("program_counter: expected %0h, got %0h",
                   want.program_counter, got.program_counter);
            fail_count = fail_count + 1;
          end
          if (got.accumulator !== want.accumulator) begin
            $error("accumulator: expected %0h, got %0h", want.accumulator, got.accumulator);
            fail_count = fail_count + 1;
          end
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
            fail_count = fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
// Top testbench for stack_machine_core: clock, reset, stimulus, stalls and verdict.
module tb;
  import sm_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic        pready;
  int          fail_count, pending;

  int          tx_idle_pct = 0, rx_idle_pct = 0;
  int          hold_req = 0, hold_seen = 0, hold_left = 0;
  int          items_sent = 0;
  logic [63:0] prog_words [$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  stack_machine_core dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sm_checker chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending
  );

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #4000000;
    $display("stack_machine_core verification failed");
    $finish;
  end

  task automatic reg_write(logic [2:0] a, logic [31:0] d);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= a; pwdata <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic offer(act_e act, logic [14:0] addr, logic [63:0] val);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data.action <= act;
    in_data.address <= addr;
    in_data.value <= val;
    do @(posedge clk_i); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  // drain, point start at base, set the stack top, load prog_words at base, start and step the core
  task automatic run_program(logic [14:0] base, logic [15:0] top, int steps);
    drain();
    reg_write(3'd0, 32'(base));
    reg_write(3'd4, 32'(top));
    foreach (prog_words[i]) offer(ACT_WRITE, base + 15'(8 * i), prog_words[i]);
    offer(ACT_START, 15'($urandom), {$urandom, $urandom});
    repeat (steps) offer(ACT_EXEC, 15'($urandom), {$urandom, $urandom});
  endtask

  function automatic logic [63:0] pick_imm(logic [5:0] op, logic [14:0] base, int n);
    case (op)
      OP_JMP, OP_JSR, OP_BZ, OP_BNZ: return 64'(base) + 64'(8 * $urandom_range(0, 2 * n));
      OP_ENT, OP_ADJ: return ($urandom_range(9) == 0) ? -64'sd2 : 64'($urandom_range(0, 4));
      OP_LEA: return 64'($signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(3))
          0: return {$urandom, $urandom};
          1: return 64'($urandom_range(0, 4095) * 8);
          2: return 64'($urandom_range(0, 32767));
          default: return 64'($signed($urandom_range(0, 16)) - 8);
        endcase
      end
    endcase
  endfunction

  task automatic random_program;
    logic [14:0] base;
    logic [15:0] top;
    logic [5:0]  op;
    int          n, r;
    base = 15'($urandom_range(0, 4000) * 8);
    if ($urandom_range(19) == 0) base = 15'h7FFF;
    r = $urandom_range(19);
    top = (r == 0) ? 16'd0 : (r == 1) ? 16'd32768 : (r == 2) ? 16'd16
        : 16'(32768 - 8 * $urandom_range(0, 64));
    n = $urandom_range(4, 12);
    prog_words.delete();
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 25)      op = OP_IMM;
      else if (r < 42) op = OP_PSH;
      else if (r < 72) op = 6'($urandom_range(OP_OR, OP_MOD));
      else if (r < 95) op = 6'($urandom_range(OP_LEA, OP_SC));
      else if (r < 97) op = OP_EXIT;
      else if (r < 98) op = 6'($urandom_range(OP_SYS0, OP_SYS7));
      else             op = 6'h3F;
      if (op == 6'h3F) prog_words.push_back({$urandom, $urandom} | 64'd64);
      else prog_words.push_back(64'(op));
      if (op <= OP_ADJ) prog_words.push_back(pick_imm(op, base, n));
    end
    run_program(base, top, n + 3);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reg_write(3'd0, 32'd0);
    reg_write(3'd4, 32'd32768);

    // halted out of reset
    offer(ACT_EXEC, 15'd0, 64'd0);
    // whole memory written first so no read ever touches an unwritten word
    for (int w = 0; w < MEM_WORDS; w++)
      offer(ACT_WRITE, 15'(8 * w),
            ($urandom_range(1)) ? 64'($urandom_range(0, 40)) : {$urandom, $urandom});
    offer(ACT_WRITE, 15'h7FFF, 64'h8000_0000_0000_0000);
    offer(ACT_WRITE, 15'h7FF8, 64'h7FFF_FFFF_FFFF_FFFF);
    offer(ACT_READ, 15'h7FF8, 64'd0);
    offer(ACT_READ, 15'h0003, '1);

    // most negative / -1, then modulo by zero
    prog_words = '{64'(OP_IMM), 64'h8000_0000_0000_0000, 64'(OP_PSH), 64'(OP_IMM), '1,
                   64'(OP_DIV), 64'(OP_PSH), 64'(OP_IMM), 64'd0, 64'(OP_MOD)};
    run_program(15'h0100, 16'd32768, 7);
    prog_words = '{64'(OP_IMM), 64'd5, 64'(OP_PSH), 64'(OP_EXIT)};
    run_program(15'h0200, 16'd32768, 4);
    prog_words = '{64'(OP_SYS0)};
    run_program(15'h0300, 16'd32768, 2);
    prog_words = '{64'd39};
    run_program(15'h0308, 16'd0, 2);
    prog_words = '{64'(OP_PSH)};
    run_program(15'h7FF8, 16'd0, 2);

    items_sent = 0;
    tx_idle_pct = 33; rx_idle_pct = 51;
    hold_req++;
    while (items_sent < 220) begin
      random_program();
      if ($urandom_range(3) == 0) offer(ACT_READ, 15'($urandom), 64'd0);
    end
    tx_idle_pct = 51; rx_idle_pct = 33;
    while (items_sent < 440) random_program();
    tx_idle_pct = 0; rx_idle_pct = 0;
    while (items_sent < 650) random_program();

    drain();
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("stack_machine_core verification clean");
    else $display("stack_machine_core verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
design/sm_pkg.sv
design/sm_ram.sv
design/sm_div.sv
design/stack_machine_core.sv
dv/sm_checker.sv
dv/tb.sv
